>>> rtl/lgg_pkg.sv
// ============================================================================
// lgg_pkg
// Shared types and constants for the life grid generation core.
// ============================================================================
package lgg_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;

    localparam int ROW_W   = $clog2(GRID_HEIGHT);
    localparam int COL_W   = $clog2(GRID_WIDTH);
    localparam int OP_W    = 3;
    localparam int ADDR_W  = 6;
    localparam int COUNT_W = 4;

    localparam logic [OP_W-1:0] OP_STEP   = 3'd0;
    localparam logic [OP_W-1:0] OP_TOGGLE = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;

    typedef logic [GRID_WIDTH-1:0] t_row;
    typedef logic [COL_W-1:0]      t_col;

    typedef struct packed {
        logic step;
        logic clear;
        logic edit;
        logic edit_val;
    } t_rule_ctl;

endpackage

>>> rtl/lgg_row_cell.sv
// ============================================================================
// lgg_row_cell
// One row of the grid. Takes the row from its neighbor on each shift.
// ============================================================================
module lgg_row_cell import lgg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  t_row i_din,
    output t_row o_row
);

    t_row r_row;
    t_row n_row;

    always_comb begin
        n_row = r_row;
        if (i_shift) begin
            n_row = i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

endmodule

>>> rtl/lgg_row_rule.sv
// ============================================================================
// lgg_row_rule
// Next value of one row: B3/S23 rule from three rows, clear, or a cell edit.
// ============================================================================
module lgg_row_rule import lgg_pkg::*; (
    input  t_row      i_prev,
    input  t_row      i_cur,
    input  t_row      i_next,
    input  t_rule_ctl i_ctl,
    input  t_col      i_col,
    output t_row      o_row
);

    logic [GRID_WIDTH+1:0] w_up;
    logic [GRID_WIDTH+1:0] w_mid;
    logic [GRID_WIDTH+1:0] w_dn;
    logic [COUNT_W-1:0]    w_cnt [GRID_WIDTH];
    t_row                  w_life;

    assign w_up  = {1'b0, i_prev, 1'b0};
    assign w_mid = {1'b0, i_cur,  1'b0};
    assign w_dn  = {1'b0, i_next, 1'b0};

    for (genvar g = 0; g < GRID_WIDTH; g++) begin : g_col
        assign w_cnt[g] = COUNT_W'(w_up[g]) + COUNT_W'(w_up[g+1]) + COUNT_W'(w_up[g+2])
                        + COUNT_W'(w_mid[g]) + COUNT_W'(w_mid[g+2])
                        + COUNT_W'(w_dn[g]) + COUNT_W'(w_dn[g+1]) + COUNT_W'(w_dn[g+2]);
        assign w_life[g] = (w_cnt[g] == BIRTH_COUNT)
                         || (i_cur[g] && (w_cnt[g] == SURVIVE_COUNT));
    end

    always_comb begin
        if (i_ctl.step) begin
            o_row = w_life;
        end else if (i_ctl.clear) begin
            o_row = '0;
        end else begin
            o_row = i_cur;
        end
        if (i_ctl.edit) begin
            o_row[i_col] = i_ctl.edit_val;
        end
    end

endmodule

>>> rtl/life_grid_generation_core.sv
// ============================================================================
// life_grid_generation_core
// Bounded B3/S23 life grid held in a ring of row cells; every operation
// rotates the ring once and rewrites each row as it passes the rule unit.
// ============================================================================
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+------------------------------------------
//  input    | i_valid  | o_stall  | i_opcode, i_cell_row, i_cell_col,
//           |          |          | i_write_value
//  output   | o_valid  | i_stall  | o_cell_value
//
//  Every item makes one full rotation of the row ring, one row per cycle
//  through the rule unit, then its result is loaded into the output
//  register. The next item is taken while a result waits in that register.
//  Reset is synchronous, active low, and clears all cells at once.
//  A stalled result holds o_stall high only once the following item is done.
// ============================================================================
module life_grid_generation_core import lgg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [ADDR_W-1:0] i_cell_row,
    input  logic [ADDR_W-1:0] i_cell_col,
    input  logic              i_write_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_cell_value
);

    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_row;
    logic [ADDR_W-1:0] r_col;
    logic              r_wv;
    logic              r_busy;
    logic [ROW_W-1:0]  r_cnt;
    t_row              r_prev;
    logic              r_pend;
    logic              r_res;
    logic              r_ovalid;
    logic              r_oval;

    t_row      w_rows [GRID_HEIGHT];
    t_row      w_next;
    t_row      w_new;
    t_col      w_col;
    t_rule_ctl w_ctl;
    logic      w_inside;
    logic      w_access;
    logic      w_hit;
    logic      w_last;
    logic      w_accept;
    logic      w_load_out;

    for (genvar k = 0; k < GRID_HEIGHT; k++) begin : g_ring
        t_row w_din;
        if (k == GRID_HEIGHT - 1) begin : g_tail
            assign w_din = w_new;
        end else begin : g_body
            assign w_din = w_rows[k+1];
        end
        lgg_row_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_busy),
            .i_din   (w_din),
            .o_row   (w_rows[k])
        );
    end

    assign w_last   = (r_cnt == ROW_W'(GRID_HEIGHT - 1));
    assign w_next   = w_last ? '0 : w_rows[1 % GRID_HEIGHT];
    assign w_col    = COL_W'(r_col);
    assign w_inside = (int'(r_row) < GRID_HEIGHT) && (int'(r_col) < GRID_WIDTH);
    assign w_access = (r_op == OP_TOGGLE) || (r_op == OP_WRITE) || (r_op == OP_READ);
    assign w_hit    = r_busy && w_inside && w_access && (r_cnt == ROW_W'(r_row));

    always_comb begin
        w_ctl.step     = (r_op == OP_STEP);
        w_ctl.clear    = (r_op == OP_CLEAR);
        w_ctl.edit     = w_hit && ((r_op == OP_TOGGLE) || (r_op == OP_WRITE));
        w_ctl.edit_val = (r_op == OP_TOGGLE) ? ~w_rows[0][w_col] : r_wv;
    end

    lgg_row_rule u_rule (
        .i_prev (r_prev),
        .i_cur  (w_rows[0]),
        .i_next (w_next),
        .i_ctl  (w_ctl),
        .i_col  (w_col),
        .o_row  (w_new)
    );

    assign w_accept   = i_valid && !o_stall;
    assign w_load_out = r_pend && (!r_ovalid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_opcode;
            r_row <= i_cell_row;
            r_col <= i_cell_col;
            r_wv  <= i_write_value;
        end
        if (w_accept) begin
            r_prev <= '0;
        end else if (r_busy) begin
            r_prev <= w_rows[0];
        end
        if (w_accept) begin
            r_res <= 1'b0;
        end else if (w_hit) begin
            r_res <= w_new[w_col];
        end
        if (w_load_out) begin
            r_oval <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= ROW_W'(r_cnt + 1'b1);
                end
            end
            if (r_busy && w_last) begin
                r_pend <= 1'b1;
            end else if (w_load_out) begin
                r_pend <= 1'b0;
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stall      = r_busy || r_pend;
    assign o_valid      = r_ovalid;
    assign o_cell_value = r_oval;

endmodule

>>> rtl/lgg_checker.sv
// ============================================================================
// lgg_checker
// Port-level checks for the life grid generation core.
// ============================================================================
module lgg_checker import lgg_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_cell_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cell_value))
        else $error("item changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("no busy after accepted item");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without work in flight");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");

endmodule

bind life_grid_generation_core lgg_checker u_lgg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_cell_value (o_cell_value)
);

>>> tb/sv/life_grid_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// life_grid_checker
// Watches both channels of the life grid core. Every accepted input item is
// applied to a private copy of the grid (B3/S23, dead border, no wrap). The
// cell value that the item should return is queued. Every accepted result is
// compared with the oldest queued value. Mismatches and results that arrive
// with nothing queued are counted.
// ============================================================================
module life_grid_checker import lgg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [ADDR_W-1:0] i_cell_row,
    input  logic [ADDR_W-1:0] i_cell_col,
    input  logic              i_write_value,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_cell_value,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
        logic              value;
    } t_cell_result;

    t_cell_result cell_result_q[$];
    t_row         life_cells [GRID_HEIGHT];
    t_row         next_cells [GRID_HEIGHT];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic live_at(int r, int c);
        if (r < 0 || c < 0 || r >= GRID_HEIGHT || c >= GRID_WIDTH) begin
            return 1'b0;
        end
        return life_cells[r][c];
    endfunction

    function automatic void next_generation();
        int n;
        for (int r = 0; r < GRID_HEIGHT; r++) begin
            for (int c = 0; c < GRID_WIDTH; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            n += live_at(r + dr, c + dc);
                        end
                    end
                end
                if (life_cells[r][c]) begin
                    next_cells[r][c] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
                end else begin
                    next_cells[r][c] = (n == BIRTH_COUNT);
                end
            end
        end
        life_cells = next_cells;
    endfunction

    function automatic logic apply_life_op(logic [OP_W-1:0] op, logic [ADDR_W-1:0] row,
                                           logic [ADDR_W-1:0] col, logic wv);
        logic on_grid;
        logic value;
        on_grid = (row < GRID_HEIGHT) && (col < GRID_WIDTH);
        value   = 1'b0;
        case (op)
            OP_STEP: begin
                next_generation();
            end
            OP_CLEAR: begin
                for (int r = 0; r < GRID_HEIGHT; r++) life_cells[r] = '0;
            end
            OP_TOGGLE, OP_WRITE, OP_READ: begin
                if (on_grid) begin
                    if (op == OP_TOGGLE) begin
                        life_cells[row][col] = ~life_cells[row][col];
                    end else if (op == OP_WRITE) begin
                        life_cells[row][col] = wv;
                    end
                    value = life_cells[row][col];
                end
            end
            default: begin
            end
        endcase
        return value;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_cell_result want;
        t_cell_result item;
        if (!i_rst_n) begin
            for (int r = 0; r < GRID_HEIGHT; r++) life_cells[r] = '0;
            cell_result_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (cell_result_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS) begin
                        $display("unexpected result: cell_value=%0b", i_cell_value);
                    end
                end else begin
                    want = cell_result_q.pop_front();
                    if (i_cell_value !== want.value) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS) begin
                            $display("cell_value mismatch: op=%0d row=%0d col=%0d exp=%0b got=%0b",
                                     want.op, want.row, want.col, want.value, i_cell_value);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                item.op    = i_opcode;
                item.row   = i_cell_row;
                item.col   = i_cell_col;
                item.value = apply_life_op(i_opcode, i_cell_row, i_cell_col, i_write_value);
                cell_result_q.push_back(item);
            end
        end
        o_pending <= cell_result_q.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Stimulus and verdict for the life grid core. A directed run covers the grid
// corners, every operation, edge clipping of patterns and unused opcodes.
// Random episodes then seed a window, step it and read it back, mixed with
// noise items. Random gaps and stalls are used throughout, and each side
// holds off for a long stretch once. The checker predicts and compares.
// ============================================================================
module tb_top;
    import lgg_pkg::*;

    localparam int LIMIT_CYCLES   = 400000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 115;
    localparam int PAUSE_AT       = DIRECTED_ITEMS + 40;
    localparam int HOLD_AT        = DIRECTED_ITEMS + 70;
    localparam int QUIET_AT       = DIRECTED_ITEMS + 110;
    localparam int LONG_HOLD      = 600;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [OP_W-1:0]   i_opcode;
    logic [ADDR_W-1:0] i_cell_row;
    logic [ADDR_W-1:0] i_cell_col;
    logic              i_write_value;
    logic              o_valid;
    logic              i_stall;
    logic              o_cell_value;

    int fail_count;
    int pending;
    int sent;
    int cycle_count;
    bit gaps_on;
    bit stalls_on;
    bit hold_req;

    life_grid_generation_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_cell_row    (i_cell_row),
        .i_cell_col    (i_cell_col),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cell_value  (o_cell_value)
    );

    life_grid_checker grid_mon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_opcode      (i_opcode),
        .i_cell_row    (i_cell_row),
        .i_cell_col    (i_cell_col),
        .i_write_value (i_write_value),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_cell_value  (o_cell_value),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin : receiver
        bit hold_done;
        i_stall = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic issue(input int op, input int row, input int col, input int wv);
        if (sent == PAUSE_AT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while (pending != 0);
        end
        if (sent == HOLD_AT) hold_req <= 1'b1;
        if (sent == QUIET_AT) begin
            gaps_on = 1'b0;
            stalls_on <= 1'b0;
        end
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= OP_W'(op);
        i_cell_row    <= ADDR_W'(row);
        i_cell_col    <= ADDR_W'(col);
        i_write_value <= 1'(wv);
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    function automatic int pick_base(int span);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return span - 8;
            default: return $urandom_range(0, span - 8);
        endcase
    endfunction

    initial begin : stimulus
        int kind;
        int r0;
        int c0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = OP_STEP;
        i_cell_row    = '0;
        i_cell_col    = '0;
        i_write_value = 1'b0;
        sent          = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        hold_req      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners, isolated cells die
        issue(OP_READ,   0,  0,  1'b0);
        issue(OP_WRITE,  0,  0,  1'b1);
        issue(OP_WRITE,  63, 63, 1'b1);
        issue(OP_TOGGLE, 0,  63, 1'b0);
        issue(OP_TOGGLE, 63, 0,  1'b1);
        issue(OP_READ,   63, 63, 1'b0);
        issue(OP_STEP,   63, 63, 1'b1);
        issue(OP_READ,   0,  0,  1'b1);
        // blinker clipped by the top edge
        issue(OP_WRITE,  0,  30, 1'b1);
        issue(OP_WRITE,  0,  31, 1'b1);
        issue(OP_WRITE,  0,  32, 1'b1);
        issue(OP_STEP,   0,  0,  1'b0);
        issue(OP_READ,   1,  31, 1'b0);
        issue(OP_READ,   0,  30, 1'b0);
        // block in the far corner is stable
        issue(OP_WRITE,  62, 62, 1'b1);
        issue(OP_WRITE,  62, 63, 1'b1);
        issue(OP_WRITE,  63, 62, 1'b1);
        issue(OP_TOGGLE, 63, 63, 1'b0);
        issue(OP_STEP,   0,  0,  1'b0);
        issue(OP_READ,   63, 63, 1'b0);
        issue(OP_WRITE,  10, 10, 1'b0);
        issue(OP_SPARE_FIRST, 63, 63, 1'b1);
        issue(OP_SPARE_LAST,  62, 62, 1'b0);
        issue(OP_CLEAR,  63, 63, 1'b1);
        issue(OP_READ,   62, 62, 1'b0);

        while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                issue($urandom_range(OP_STEP, OP_SPARE_LAST), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom_range(0, 1));
            end else if (kind == 1) begin
                issue(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 1));
            end else begin
                r0 = pick_base(GRID_HEIGHT);
                c0 = pick_base(GRID_WIDTH);
                repeat ($urandom_range(6, 14)) begin
                    issue(($urandom_range(0, 3) == 0) ? OP_TOGGLE : OP_WRITE,
                          r0 + $urandom_range(0, 7), c0 + $urandom_range(0, 7),
                          $urandom_range(0, 3) != 0);
                end
                repeat ($urandom_range(1, 3)) begin
                    issue(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1));
                end
                repeat ($urandom_range(3, 6)) begin
                    issue(OP_READ, r0 + $urandom_range(0, 7), c0 + $urandom_range(0, 7),
                          $urandom_range(0, 1));
                end
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
